>>> rtl/gcev_pkg.sv
// shared types, constants and flag functions of the gamepad change event generator
package gcev_pkg;

  // flag vector layout
  localparam int FLAG_COUNT  = 24;
  localparam int INDEX_W     = 5;

  // register widths and reset values
  localparam int THRESH_W    = 8;
  localparam int ZONE_W      = 15;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 15;
  localparam logic [THRESH_W-1:0] THRESH_RESET    = 8'd30;
  localparam logic [ZONE_W-1:0]   DEAD_ZONE_RESET = 15'd9830;
  localparam logic [ZONE_W-1:0]   CENTRE_RESET    = 15'd3277;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PRESSURE_THRESHOLD = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_AXIS_DEAD_ZONE     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CENTRE_ZONE        = 2'd2;

  // stream widths
  localparam int IN_DATA_W   = 136;
  localparam int OUT_DATA_W  = 8;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // one poll that changed at least one flag
  typedef struct packed {
    logic [FLAG_COUNT-1:0] diff;
    logic [FLAG_COUNT-1:0] flags;
  } gcev_entry_t;

  // bit 0 positive direction, bit 1 negative direction
  function automatic logic [1:0] axis_flags(input logic signed [15:0] v,
                                            input logic [ZONE_W-1:0] dz,
                                            input logic [ZONE_W-1:0] cz);
    logic signed [16:0] v17;
    logic signed [16:0] cz17;
    logic signed [16:0] dz17;
    logic               in_centre;
    logic [1:0]         f;
    v17       = {v[15], v};
    cz17      = {2'b00, cz};
    dz17      = {2'b00, dz};
    in_centre = (v17 > -cz17) && (v17 < cz17);
    f[0]      = !in_centre && (v17 > dz17);
    f[1]      = !in_centre && (v17 < -dz17);
    return f;
  endfunction

endpackage

>>> rtl/gcev_front.sv
// front part: config registers, flag classification and held flag vector
module gcev_front
  import gcev_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  full,
  output logic                  push,
  output gcev_entry_t           push_entry
);

  logic [THRESH_W-1:0]   pressure_threshold;
  logic [ZONE_W-1:0]     axis_dead_zone;
  logic [ZONE_W-1:0]     centre_zone;
  logic [FLAG_COUNT-1:0] flag_vector;
  logic [FLAG_COUNT-1:0] new_flags;
  logic [FLAG_COUNT-1:0] diff;
  logic [1:0]            ly, lx, ry, rx;
  logic                  accept;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pressure_threshold <= THRESH_RESET;
      axis_dead_zone     <= DEAD_ZONE_RESET;
      centre_zone        <= CENTRE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PRESSURE_THRESHOLD: pressure_threshold <= cfg_wdata[THRESH_W-1:0];
        REG_AXIS_DEAD_ZONE:     axis_dead_zone     <= cfg_wdata[ZONE_W-1:0];
        REG_CENTRE_ZONE:        centre_zone        <= cfg_wdata[ZONE_W-1:0];
        default: ;
      endcase
    end
  end

  // classify one poll into 24 flags
  always_comb begin
    ly = axis_flags(s_tdata[87:72],   axis_dead_zone, centre_zone);
    lx = axis_flags(s_tdata[103:88],  axis_dead_zone, centre_zone);
    ry = axis_flags(s_tdata[119:104], axis_dead_zone, centre_zone);
    rx = axis_flags(s_tdata[135:120], axis_dead_zone, centre_zone);
    new_flags[7:0] = s_tdata[7:0];
    for (int i = 0; i < 8; i++) begin
      new_flags[8+i] = s_tdata[8+8*i +: 8] > pressure_threshold;
    end
    new_flags[16] = ly[0];
    new_flags[17] = ly[1];
    new_flags[18] = lx[1];
    new_flags[19] = lx[0];
    new_flags[20] = ry[0];
    new_flags[21] = ry[1];
    new_flags[22] = rx[1];
    new_flags[23] = rx[0];
  end

  // compare with held flags, queue only polls that change something
  assign diff             = new_flags ^ flag_vector;
  assign s_tready         = !full;
  assign accept           = s_tvalid && s_tready;
  assign push             = accept && (diff != '0);
  assign push_entry.diff  = diff;
  assign push_entry.flags = new_flags;

  // held flag vector
  always_ff @(posedge clk) begin
    if (rst) begin
      flag_vector <= '0;
    end else if (accept) begin
      flag_vector <= new_flags;
    end
  end

  a_flags_follow: assert property (@(posedge clk) disable iff (rst)
    accept |=> flag_vector == $past(new_flags))
    else $error("held flags not updated by accepted poll");

  a_push_has_change: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_entry.diff != '0) && !full)
    else $error("queued poll without change or into full queue");

endmodule

>>> rtl/gcev_fifo.sv
// short queue of changed polls between front and back
module gcev_fifo
  import gcev_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  gcev_entry_t push_entry,
  input  logic        pop,
  output gcev_entry_t head,
  output logic        empty,
  output logic        full
);

  gcev_entry_t             mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]  wr_ptr;
  logic [QUEUE_PTR_W-1:0]  rd_ptr;
  logic [QUEUE_CNT_W-1:0]  count;

  assign empty = count == '0;
  assign full  = count == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign head  = mem[rd_ptr];

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("pop from empty queue");

endmodule

>>> rtl/gcev_back.sv
// back part: walks the changed flags of the queue head and emits one event a cycle while the output is not stalled
module gcev_back
  import gcev_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  gcev_entry_t           head,
  input  logic                  empty,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  logic [FLAG_COUNT-1:0] done_mask;
  logic [FLAG_COUNT-1:0] done_mask_next;
  logic [FLAG_COUNT-1:0] remaining;
  logic [FLAG_COUNT-1:0] pick;
  logic [INDEX_W-1:0]    idx;
  logic                  single;
  logic                  issue;

  // changes of the head entry not yet sent
  assign remaining = head.diff & ~done_mask;

  // lowest changed flag first
  always_comb begin
    idx = '0;
    for (int i = FLAG_COUNT - 1; i >= 0; i--) begin
      if (remaining[i]) idx = INDEX_W'(i);
    end
  end

  assign pick   = remaining & (~remaining + 1'b1);
  assign single = (remaining & ~pick) == '0;
  assign issue  = !empty && (!m_tvalid || m_tready);
  assign pop    = issue && single;

  // progress through the head entry
  always_comb begin
    done_mask_next = done_mask;
    if (issue) begin
      done_mask_next = single ? '0 : (done_mask | pick);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_mask <= '0;
    end else begin
      done_mask <= done_mask_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (issue) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      m_tdata <= {{(OUT_DATA_W - INDEX_W - 1){1'b0}}, head.flags[idx], idx};
      m_tlast <= single;
    end
  end

  a_issue_has_work: assert property (@(posedge clk) disable iff (rst)
    issue |-> remaining != '0)
    else $error("event requested with no changed flag left");

  a_done_cleared_on_pop: assert property (@(posedge clk) disable iff (rst)
    pop |=> done_mask == '0)
    else $error("progress mask not cleared after last event");

endmodule

>>> rtl/gamepad_change_event_generator_unit.sv
// Top level: poll classification, change queue and event sequencer.
// The first event of a poll passes through the queue entry and then the output register.
// Throughput: one event per cycle while m_tready holds; a poll with n changed flags gives n events,
// a poll with no change none. Polls are taken every cycle while the 2-entry queue has room.
// Reset (rst, synchronous): held flags cleared, registers to 30 / 9830 / 3277, queue emptied.
module gamepad_change_event_generator_unit
  import gcev_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // digital_buttons[7:0], pressures[71:8], left_stick_y[87:72], left_stick_x[103:88],
  // right_stick_y[119:104], right_stick_x[135:120]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // event_index[4:0], pressed[5], zero fill[7:6]
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  gcev_entry_t push_entry;
  gcev_entry_t head;
  logic        push;
  logic        pop;
  logic        empty;
  logic        full;

  gcev_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .full       (full),
    .push       (push),
    .push_entry (push_entry)
  );

  gcev_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  gcev_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

>>> sim/tb_gamepad_change_event_generator_unit.sv
// testbench for the gamepad change event generator: predicted flag events vs. the stream
`timescale 1ns / 100ps

module tb_gamepad_change_event_generator_unit;
  import gcev_pkg::*;

  // address with no register behind it, writes there are dropped
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

  // one change event as seen on the master side
  typedef struct {
    logic [INDEX_W-1:0] flag_idx;
    logic               pressed;
    logic               is_last;
  } flag_event_t;

  // keeps the held flags and registers, predicts the events of each request
  class flag_change_board;
    logic [THRESH_W-1:0]   threshold;
    logic [ZONE_W-1:0]     dead_zone;
    logic [ZONE_W-1:0]     centre;
    logic [FLAG_COUNT-1:0] held_flags;
    flag_event_t           pending_events[$];
    int                    mismatches;
    int                    events_seen;

    function new();
      threshold   = THRESH_RESET;
      dead_zone   = DEAD_ZONE_RESET;
      centre      = CENTRE_RESET;
      held_flags  = '0;
      mismatches  = 0;
      events_seen = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_PRESSURE_THRESHOLD: threshold = val[THRESH_W-1:0];
        REG_AXIS_DEAD_ZONE:     dead_zone = val;
        REG_CENTRE_ZONE:        centre    = val;
        default: ;
      endcase
    endfunction

    // bit 0 positive direction, bit 1 negative direction
    function logic [1:0] stick_dirs(logic [15:0] raw);
      int v;
      int dz;
      int cz;
      v  = $signed(raw);
      dz = dead_zone;
      cz = centre;
      if (v > -cz && v < cz) v = 0;
      return {v < -dz, v > dz};
    endfunction

    function void take_poll(logic [IN_DATA_W-1:0] d);
      logic [FLAG_COUNT-1:0] nf;
      logic [FLAG_COUNT-1:0] diff;
      logic [1:0]            ly, lx, ry, rx;
      int                    last_i;
      flag_event_t           ev;
      nf[7:0] = d[7:0];
      for (int i = 0; i < 8; i++) nf[8+i] = d[8+8*i +: 8] > threshold;
      ly = stick_dirs(d[87:72]);
      lx = stick_dirs(d[103:88]);
      ry = stick_dirs(d[119:104]);
      rx = stick_dirs(d[135:120]);
      // up, down, left, right per stick
      nf[23:16] = {rx[0], rx[1], ry[1], ry[0], lx[0], lx[1], ly[1], ly[0]};
      diff   = nf ^ held_flags;
      last_i = -1;
      for (int i = 0; i < FLAG_COUNT; i++) if (diff[i]) last_i = i;
      for (int i = 0; i < FLAG_COUNT; i++) begin
        if (diff[i]) begin
          ev.flag_idx = INDEX_W'(i);
          ev.pressed  = nf[i];
          ev.is_last  = (i == last_i);
          pending_events.push_back(ev);
        end
      end
      held_flags = nf;
    endfunction

    function void check_event(logic [OUT_DATA_W-1:0] data, logic tl);
      flag_event_t exp_ev;
      events_seen++;
      if (pending_events.size() == 0) begin
        $error("unexpected event: event_index %0d pressed %0d last_event %0d",
               data[4:0], data[5], tl);
        mismatches++;
        return;
      end
      exp_ev = pending_events.pop_front();
      if (data[4:0] !== exp_ev.flag_idx) begin
        $error("event_index: expected %0d, actual %0d", exp_ev.flag_idx, data[4:0]);
        mismatches++;
      end
      if (data[5] !== exp_ev.pressed) begin
        $error("pressed: expected %0d, actual %0d", exp_ev.pressed, data[5]);
        mismatches++;
      end
      if (tl !== exp_ev.is_last) begin
        $error("last_event: expected %0d, actual %0d", exp_ev.is_last, tl);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  flag_change_board board = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int polls_sent     = 0;
  int settings_used  = 1;

  gamepad_change_event_generator_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always #10 clk = ~clk;

  function automatic logic [IN_DATA_W-1:0] pack_poll(logic [7:0] buttons,
                                                     logic [63:0] pressures,
                                                     int ly, int lx, int ry, int rx);
    return {rx[15:0], ry[15:0], lx[15:0], ly[15:0], pressures, buttons};
  endfunction

  // pressure byte near the current threshold, at the ends of its range or anywhere
  function automatic logic [7:0] pick_pressure();
    case ($urandom_range(4))
      0:       return board.threshold;
      1:       return board.threshold + 8'd1;
      2:       return 8'd0;
      3:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // axis value around the zone edges, at full scale, at zero or anywhere
  function automatic logic [15:0] pick_axis();
    int dz;
    int cz;
    int v;
    dz = board.dead_zone;
    cz = board.centre;
    case ($urandom_range(11))
      0:       v = dz;
      1:       v = dz + 1;
      2:       v = -dz;
      3:       v = -dz - 1;
      4:       v = cz;
      5:       v = cz - 1;
      6:       v = -cz;
      7:       v = 1 - cz;
      8:       v = 32767;
      9:       v = -32768;
      10:      v = 0;
      default: v = $urandom_range(16'hFFFF);
    endcase
    return v[15:0];
  endfunction

  // fresh biased poll, a repeat, or the previous one with one to three bits flipped
  function automatic logic [IN_DATA_W-1:0] random_poll(logic [IN_DATA_W-1:0] prev);
    logic [IN_DATA_W-1:0] d;
    int                   roll;
    roll = $urandom_range(99);
    if (roll < 70) begin
      d[7:0] = 8'($urandom_range(255));
      for (int i = 0; i < 8; i++) d[8+8*i +: 8] = pick_pressure();
      for (int i = 0; i < 4; i++) d[72+16*i +: 16] = pick_axis();
    end else if (roll < 85) begin
      d = prev;
    end else begin
      d = prev;
      repeat ($urandom_range(1, 3)) d[$urandom_range(IN_DATA_W-1)] ^= 1'b1;
    end
    return d;
  endfunction

  // present one request, with random idle cycles in front of it
  task automatic send_poll(input logic [IN_DATA_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= d;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    board.take_poll(d);
    polls_sent++;
  endtask

  // stop sending and let every predicted event come out
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // leaves cfg_we high, the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  task automatic set_zones(input logic [CFG_DATA_W-1:0] thr,
                           input logic [CFG_DATA_W-1:0] dz,
                           input logic [CFG_DATA_W-1:0] cz);
    write_reg(REG_PRESSURE_THRESHOLD, thr);
    write_reg(REG_AXIS_DEAD_ZONE, dz);
    write_reg(REG_CENTRE_ZONE, cz);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(15'h7FFF)));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] random_reg_value(int full);
    case ($urandom_range(3))
      0:       return '0;
      1:       return CFG_DATA_W'(full);
      2:       return CFG_DATA_W'($urandom_range(15'h7FFF));
      default: return CFG_DATA_W'($urandom_range(full / 2));
    endcase
  endfunction

  // event monitor and random backpressure
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) board.check_event(m_tdata, m_tlast);
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [IN_DATA_W-1:0] prev;
    int                   idle_by_phase[4];
    int                   stall_by_phase[4];
    idle_by_phase  = '{0, 52, 0, 33};
    stall_by_phase = '{0, 0, 52, 33};
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: full scale, thresholds, dead zone and centre zone edges
    send_poll(pack_poll(8'h00, 64'h0, 0, 0, 0, 0));
    send_poll(pack_poll(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 32767, -32768, -32768, 32767));
    send_poll(pack_poll(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 32767, -32768, -32768, 32767));
    send_poll(pack_poll(8'h55, 64'h1F1E_1F1E_1F1E_1F1E, -9831, 9831, 9830, -9830));
    send_poll(pack_poll(8'hAA, 64'h1E1F_1E1F_1E1F_1E1F, 9831, -9831, -9831, 9831));
    send_poll(pack_poll(8'h00, 64'h0, 3276, -3276, 3277, -3277));
    send_poll(pack_poll(8'h00, 64'h0, 0, 0, 0, 0));
    drain();

    // threshold from an over-wide value, zero zones: strict compares at zero
    set_zones(15'h7FFF, 15'd0, 15'd0);
    send_poll(pack_poll(8'h0F, 64'hFFFF_FFFF_FFFF_FFFF, 1, -1, 0, 0));
    send_poll(pack_poll(8'hF0, 64'hFEFE_FEFE_FEFE_FEFE, -1, 1, 1, -1));
    send_poll(pack_poll(8'h00, 64'h0, 0, 0, 0, 0));
    drain();

    // centre zone wider than the dead zone
    set_zones(15'd0, 15'd0, 15'd100);
    send_poll(pack_poll(8'h00, 64'h0100_0100_0100_0100, 99, -99, 100, -100));
    send_poll(pack_poll(8'h00, 64'h0, 101, -101, 99, -99));
    drain();

    // widest zones: on the sticks only negative full scale survives
    set_zones(15'd254, 15'h7FFF, 15'h7FFF);
    send_poll(pack_poll(8'hFF, 64'hFFFE_FFFE_FFFE_FFFE, 32767, -32768, -32767, -32768));
    send_poll(pack_poll(8'h00, 64'h0, 0, 0, 0, 0));
    drain();

    // random polls in four throttling phases, new register settings for each
    prev = '0;
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 0) set_zones(CFG_DATA_W'(THRESH_RESET), DEAD_ZONE_RESET, CENTRE_RESET);
      else set_zones(random_reg_value(255), random_reg_value(32767),
                     random_reg_value(32767));
      send_idle_pct  = idle_by_phase[ph];
      recv_stall_pct = stall_by_phase[ph];
      repeat (112) begin
        prev = random_poll(prev);
        send_poll(prev);
      end
      drain();
    end

    recv_stall_pct = 0;
    $display("%0d polls sent, %0d change events checked", polls_sent, board.events_seen);
    $display("%0d register settings, four idle/stall mixes", settings_used);
    if (board.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
